FILE: design/cts_pkg.sv
// Shared types, constants and character tables of the source tokenizer.
package cts_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS = 16;
  localparam int KEYWORD_MAX_LEN = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int KW_CMP_LEN = 9;
  localparam int KW_COUNT = 18;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [6:0] kind_t;
  typedef logic [1:0] err_t;

  localparam offset_t OFS_SAT = {OFFSET_BITS{1'b1}};
  localparam line_t LINE_SAT = {LINE_BITS{1'b1}};

  localparam kind_t K_SLASH_EQ = 7'd25;
  localparam kind_t K_SLASH = 7'd26;
  localparam kind_t K_STRING = 7'd41;
  localparam kind_t K_CHAR = 7'd42;
  localparam kind_t K_INT = 7'd43;
  localparam kind_t K_DOUBLE = 7'd44;
  localparam kind_t K_FLOAT = 7'd45;
  localparam kind_t K_IDENT = 7'd46;
  localparam kind_t K_KEY0 = 7'd47;
  localparam kind_t K_EOF = 7'd65;
  localparam kind_t K_ERROR = 7'd66;
  localparam kind_t K_NONE = 7'd127;

  localparam err_t E_NONE = 2'd0;
  localparam err_t E_CHAR = 2'd1;
  localparam err_t E_STRING = 2'd2;
  localparam err_t E_QUOTE = 2'd3;

  typedef enum logic [3:0] {
    C_WS, C_NL, C_SLASH, C_PAIR, C_SINGLE, C_DQ, C_SQ, C_ALPHA, C_DIGIT, C_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [6:0] token_kind;
    line_t      line_number;
    offset_t    start_offset;
    offset_t    lexeme_length;
    logic [1:0] error_code;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
    cls_t       cls;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  localparam logic [71:0] KW_STR [KW_COUNT] = '{
    "using", "namespace", "class", "if", "else", "int", "float", "double",
    "char", "string", "bool", "void", "while", "for", "true", "false",
    "null", "return"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd9, 4'd5, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd5, 4'd3, 4'd4, 4'd5, 4'd4, 4'd6
  };

  function automatic offset_t next_off(offset_t x);
    return (x == OFS_SAT) ? OFS_SAT : x + offset_t'(1);
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    case (c)
      "{": return 7'd0;
      "}": return 7'd1;
      "[": return 7'd2;
      "]": return 7'd3;
      "(": return 7'd4;
      ")": return 7'd5;
      "<": return 7'd8;
      ">": return 7'd11;
      ".": return 7'd12;
      ",": return 7'd13;
      ";": return 7'd14;
      ":": return 7'd15;
      "*": return 7'd17;
      "+": return 7'd20;
      "-": return 7'd24;
      "/": return K_SLASH;
      "%": return 7'd27;
      "!": return 7'd29;
      "=": return 7'd31;
      "&": return 7'd34;
      "|": return 7'd37;
      "^": return 7'd39;
      "~": return 7'd40;
      default: return K_NONE;
    endcase
  endfunction

  function automatic kind_t pair_kind(logic [7:0] a, logic [7:0] b);
    case (a)
      "<": return (b == "=") ? 7'd6 : (b == "<") ? 7'd7 : K_NONE;
      ">": return (b == "=") ? 7'd9 : (b == ">") ? 7'd10 : K_NONE;
      "*": return (b == "=") ? 7'd16 : K_NONE;
      "+": return (b == "+") ? 7'd18 : (b == "=") ? 7'd19 : K_NONE;
      "-": return (b == "-") ? 7'd21 : (b == "=") ? 7'd22 : (b == ">") ? 7'd23 : K_NONE;
      "!": return (b == "=") ? 7'd28 : K_NONE;
      "=": return (b == "=") ? 7'd30 : K_NONE;
      "&": return (b == "=") ? 7'd32 : (b == "&") ? 7'd33 : K_NONE;
      "|": return (b == "=") ? 7'd35 : (b == "|") ? 7'd36 : K_NONE;
      "^": return (b == "=") ? 7'd38 : K_NONE;
      default: return K_NONE;
    endcase
  endfunction

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    if (c == " " || c == 8'h09 || c == 8'h0D) r = C_WS;
    else if (c == 8'h0A) r = C_NL;
    else if (c == "/") r = C_SLASH;
    else if (c == "<" || c == ">" || c == "*" || c == "+" || c == "-" ||
             c == "!" || c == "=" || c == "&" || c == "|" || c == "^") r = C_PAIR;
    else if (single_kind(c) != K_NONE) r = C_SINGLE;
    else if (c == 8'h22) r = C_DQ;
    else if (c == 8'h27) r = C_SQ;
    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") r = C_ALPHA;
    else if (c >= "0" && c <= "9") r = C_DIGIT;
    else r = C_OTHER;
    return r;
  endfunction

  // Word bytes are packed with the first byte in the top byte lane.
  function automatic kind_t keyword_kind(logic [71:0] key, logic [4:0] n);
    kind_t r;
    logic [71:0] mask;
    r = K_IDENT;
    mask = ~({72{1'b1}} >> (8 * n));
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if ({1'b0, KW_LEN[i]} == n &&
          ((key ^ (KW_STR[i] << (8 * (KW_CMP_LEN - int'(KW_LEN[i]))))) & mask) == '0) begin
        r = K_KEY0 + kind_t'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/c_like_source_tokenizer.sv
// Top level of the streaming tokenizer for a small C-like language.
// Source bytes enter one per request and are queued four deep; the scanner
// takes one step per cycle whenever the result register is free and writes at
// most one token record per step. A byte that ends a pending token without
// being part of it is scanned again, and a byte that breaks a character
// literal first has the held byte scanned again. The queue lets bytes keep
// arriving while the scanner rescans bytes or results wait.
module c_like_source_tokenizer #(
  parameter int KEYWORD_MAX_LEN = cts_pkg::KEYWORD_MAX_LEN
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cts_pkg::out_t out_data
);

  cts_pkg::q_head_t head;
  logic pop;

  cts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  cts_back #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/cts_front.sv
// Front end of the tokenizer: accepts bytes, classifies them and queues them.
module cts_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cts_pkg::in_t    in_data,
  output cts_pkg::q_head_t head,
  input  logic            pop
);

  localparam int PW = $clog2(cts_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(cts_pkg::QUEUE_DEPTH + 1);

  cts_pkg::q_item_t mem_r [cts_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] count_r;
  logic push;
  logic pop_ok;
  cts_pkg::q_item_t item;

  assign in_ready = (count_r != CW'(cts_pkg::QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign pop_ok = pop && (count_r != '0);

  always_comb begin
    item.byte_value = in_data.byte_value;
    item.end_of_input = in_data.end_of_input;
    item.cls = cts_pkg::classify(in_data.byte_value);
  end

  assign head.valid = (count_r != '0);
  assign head.item = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(cts_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop_ok) begin
        rptr_r <= (rptr_r == PW'(cts_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop_ok) begin
        count_r <= count_r + CW'(1);
      end else if (pop_ok && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: design/cts_back.sv
// Back end of the tokenizer: the scanner state machine and the result register.
module cts_back #(
  parameter int KEYWORD_MAX_LEN = cts_pkg::KEYWORD_MAX_LEN
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cts_pkg::q_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cts_pkg::out_t    out_data
);

  localparam int IW = $clog2(KEYWORD_MAX_LEN);

  typedef enum logic [3:0] {
    M_IDLE, M_PUNCT, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_WORD, M_INT,
    M_FRAC, M_STR, M_QUOTE, M_QCHAR
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic replay_r, replay_nxt;
  logic [7:0] held_r, held_nxt;
  cts_pkg::line_t line_r, line_nxt;
  cts_pkg::offset_t pos_r;
  cts_pkg::offset_t tb_r, tb_nxt;
  logic wtl_r, wtl_nxt;
  logic [7:0] wbuf_r [KEYWORD_MAX_LEN];
  logic out_valid_r;
  cts_pkg::out_t out_data_r;

  logic fire, again, emit, reset_all, line_inc, do_start, do_wend, last;
  logic wp_req, wp_long, wp_start;
  cts_pkg::offset_t wp_idx, wp_off, wp_base;
  cts_pkg::kind_t e_kind;
  cts_pkg::offset_t e_start, e_end, e_len, k, off, st_o, wend_n;
  cts_pkg::err_t e_err;
  logic [7:0] c, st_b;
  cts_pkg::cls_t ccls, hcls, st_cls;
  logic [71:0] key;
  cts_pkg::kind_t wend_kind;
  logic tail;

  function automatic mode_t start_mode(cts_pkg::cls_t s);
    case (s)
      cts_pkg::C_SLASH: return M_SLASH;
      cts_pkg::C_PAIR:  return M_PUNCT;
      cts_pkg::C_DQ:    return M_STR;
      cts_pkg::C_SQ:    return M_QUOTE;
      cts_pkg::C_ALPHA: return M_WORD;
      cts_pkg::C_DIGIT: return M_INT;
      default:          return M_IDLE;
    endcase
  endfunction

  function automatic logic start_emits(cts_pkg::cls_t s);
    return (s == cts_pkg::C_SINGLE) || (s == cts_pkg::C_OTHER);
  endfunction

  // Whether feeding one byte in the given mode yields any token at all.
  function automatic logic feed_emits(mode_t m, cts_pkg::cls_t s, logic [7:0] b);
    case (m)
      M_IDLE:  return start_emits(s);
      M_PUNCT: return 1'b1;
      M_SLASH: return (b != "/") && (b != "*");
      M_WORD:  return (s != cts_pkg::C_ALPHA) && (s != cts_pkg::C_DIGIT);
      M_INT:   return (s != cts_pkg::C_DIGIT) && (b != ".");
      M_FRAC:  return (s != cts_pkg::C_DIGIT);
      M_STR:   return (b == 8'h22);
      M_QCHAR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  always_comb begin
    key = '0;
    for (int i = 0; i < cts_pkg::KW_CMP_LEN; i++) begin
      key[71 - 8 * i -: 8] = wbuf_r[i];
    end
  end

  assign c = head.item.byte_value;
  assign ccls = head.item.cls;
  assign hcls = cts_pkg::classify(held_r);
  assign off = pos_r;
  assign k = cts_pkg::next_off(tb_r);
  assign st_b = replay_r ? held_r : c;
  assign st_o = replay_r ? k : off;
  assign st_cls = replay_r ? hcls : ccls;
  assign wend_n = off - tb_r;
  assign wend_kind = (!wtl_r && wend_n <= cts_pkg::offset_t'(KEYWORD_MAX_LEN)) ?
                     cts_pkg::keyword_kind(key, wend_n[4:0]) : cts_pkg::K_IDENT;

  always_comb begin
    mode_nxt = mode_r;
    replay_nxt = replay_r;
    held_nxt = held_r;
    tb_nxt = tb_r;
    wtl_nxt = wtl_r;
    again = 1'b0;
    emit = 1'b0;
    reset_all = 1'b0;
    line_inc = 1'b0;
    do_start = 1'b0;
    do_wend = 1'b0;
    wp_req = 1'b0;
    wp_start = 1'b0;
    e_kind = cts_pkg::K_ERROR;
    e_start = tb_r;
    e_end = off;
    e_err = cts_pkg::E_NONE;
    if (replay_r) begin
      do_start = 1'b1;
      replay_nxt = 1'b0;
      again = 1'b1;
    end else if (head.item.end_of_input) begin
      mode_nxt = M_IDLE;
      again = 1'b1;
      case (mode_r)
        M_QCHAR: begin
          emit = 1'b1;
          e_start = k;
          e_end = k;
          e_err = cts_pkg::E_QUOTE;
          replay_nxt = 1'b1;
        end
        M_PUNCT: begin
          emit = 1'b1;
          e_kind = cts_pkg::single_kind(held_r);
        end
        M_SLASH: begin
          emit = 1'b1;
          e_kind = cts_pkg::K_SLASH;
        end
        M_WORD: do_wend = 1'b1;
        M_INT: begin
          emit = 1'b1;
          e_kind = cts_pkg::K_INT;
        end
        M_FRAC: begin
          emit = 1'b1;
          e_kind = cts_pkg::K_DOUBLE;
        end
        M_STR: begin
          emit = 1'b1;
          e_start = k;
          e_err = cts_pkg::E_STRING;
        end
        M_QUOTE: begin
          emit = 1'b1;
          e_start = k;
          e_end = k;
          e_err = cts_pkg::E_QUOTE;
        end
        default: begin
          emit = 1'b1;
          again = 1'b0;
          reset_all = 1'b1;
          e_kind = cts_pkg::K_EOF;
          e_start = off;
        end
      endcase
    end else begin
      case (mode_r)
        M_PUNCT: begin
          mode_nxt = M_IDLE;
          emit = 1'b1;
          if (cts_pkg::pair_kind(held_r, c) != cts_pkg::K_NONE) begin
            e_kind = cts_pkg::pair_kind(held_r, c);
            e_end = cts_pkg::next_off(off);
          end else begin
            e_kind = cts_pkg::single_kind(held_r);
            again = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_nxt = M_LCOM;
          end else if (c == "*") begin
            mode_nxt = M_BCOM;
          end else if (c == "=") begin
            emit = 1'b1;
            e_kind = cts_pkg::K_SLASH_EQ;
            e_end = cts_pkg::next_off(off);
            mode_nxt = M_IDLE;
          end else begin
            emit = 1'b1;
            e_kind = cts_pkg::K_SLASH;
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_LCOM: begin
          if (ccls == cts_pkg::C_NL) begin
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_BCOM, M_BSTAR: begin
          line_inc = (ccls == cts_pkg::C_NL);
          if (mode_r == M_BSTAR && c == "/") mode_nxt = M_IDLE;
          else mode_nxt = (c == "*") ? M_BSTAR : M_BCOM;
        end
        M_WORD: begin
          if (ccls == cts_pkg::C_ALPHA || ccls == cts_pkg::C_DIGIT) begin
            wp_req = 1'b1;
          end else begin
            do_wend = 1'b1;
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (ccls == cts_pkg::C_DIGIT) begin
            mode_nxt = mode_r;
          end else if (c == "." && mode_r == M_INT) begin
            mode_nxt = M_FRAC;
          end else if (c == "f" || c == "F") begin
            emit = 1'b1;
            e_kind = cts_pkg::K_FLOAT;
            e_end = cts_pkg::next_off(off);
            mode_nxt = M_IDLE;
          end else begin
            emit = 1'b1;
            e_kind = (mode_r == M_INT) ? cts_pkg::K_INT : cts_pkg::K_DOUBLE;
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_STR: begin
          if (ccls == cts_pkg::C_DQ) begin
            emit = 1'b1;
            e_kind = cts_pkg::K_STRING;
            e_start = k;
            mode_nxt = M_IDLE;
          end else begin
            line_inc = (ccls == cts_pkg::C_NL);
          end
        end
        M_QUOTE: begin
          held_nxt = c;
          mode_nxt = M_QCHAR;
        end
        M_QCHAR: begin
          emit = 1'b1;
          e_start = k;
          mode_nxt = M_IDLE;
          if (ccls == cts_pkg::C_SQ) begin
            line_inc = (hcls == cts_pkg::C_NL);
            e_kind = cts_pkg::K_CHAR;
          end else begin
            e_end = k;
            e_err = cts_pkg::E_QUOTE;
            replay_nxt = 1'b1;
            again = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    if (do_start) begin
      tb_nxt = st_o;
      mode_nxt = start_mode(st_cls);
      e_start = st_o;
      e_end = cts_pkg::next_off(st_o);
      case (st_cls)
        cts_pkg::C_NL: line_inc = 1'b1;
        cts_pkg::C_PAIR: held_nxt = st_b;
        cts_pkg::C_SINGLE: begin
          emit = 1'b1;
          e_kind = cts_pkg::single_kind(st_b);
        end
        cts_pkg::C_ALPHA: begin
          wp_req = 1'b1;
          wp_start = 1'b1;
        end
        cts_pkg::C_OTHER: begin
          emit = 1'b1;
          e_kind = cts_pkg::K_ERROR;
          e_err = cts_pkg::E_CHAR;
        end
        default: mode_nxt = start_mode(st_cls);
      endcase
    end

    if (do_wend) begin
      emit = 1'b1;
      e_kind = wend_kind;
    end

    wp_off = wp_start ? st_o : off;
    wp_base = wp_start ? st_o : tb_r;
    wp_idx = wp_off - wp_base;
    wp_long = (wp_off == cts_pkg::OFS_SAT) ||
              (wp_idx >= cts_pkg::offset_t'(KEYWORD_MAX_LEN));
    if (wp_req) begin
      wtl_nxt = (wp_start ? 1'b0 : wtl_r) | wp_long;
    end

    line_nxt = (line_inc && line_r != cts_pkg::LINE_SAT) ?
               line_r + cts_pkg::line_t'(1) : line_r;
  end

  assign e_len = (e_end >= e_start) ? e_end - e_start : '0;

  // A record closes its run when no later step of the same request emits.
  always_comb begin
    if (replay_nxt) tail = start_emits(hcls) || feed_emits(start_mode(hcls), ccls, c);
    else tail = feed_emits(mode_nxt, ccls, c);
    if (head.item.end_of_input) last = reset_all;
    else last = !again || !tail;
  end

  assign fire = head.valid && (!out_valid_r || out_ready);
  assign pop = fire && !again;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (fire && wp_req && !wp_long) begin
      wbuf_r[wp_idx[IW-1:0]] <= st_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      replay_r <= 1'b0;
      held_r <= '0;
      line_r <= cts_pkg::line_t'(1);
      pos_r <= '0;
      tb_r <= '0;
      wtl_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (reset_all) begin
          mode_r <= M_IDLE;
          replay_r <= 1'b0;
          held_r <= '0;
          line_r <= cts_pkg::line_t'(1);
          pos_r <= '0;
          tb_r <= '0;
          wtl_r <= 1'b0;
        end else begin
          mode_r <= mode_nxt;
          replay_r <= replay_nxt;
          held_r <= held_nxt;
          line_r <= line_nxt;
          tb_r <= tb_nxt;
          wtl_r <= wtl_nxt;
          if (!again) pos_r <= cts_pkg::next_off(pos_r);
        end
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
        out_data_r.token_kind <= e_kind;
        out_data_r.line_number <= line_nxt;
        out_data_r.start_offset <= e_start;
        out_data_r.lexeme_length <= e_len;
        out_data_r.error_code <= e_err;
        out_data_r.last_of_run <= last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_replay_idle: assert property (@(posedge clk) disable iff (!rst_n)
    replay_r |-> mode_r == M_IDLE)
    else $error("held byte replay pending outside idle mode");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.error_code != cts_pkg::E_NONE) ==
                     (out_data_r.token_kind == cts_pkg::K_ERROR)))
    else $error("error code and token kind disagree");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.token_kind == cts_pkg::K_EOF) |-> out_data_r.last_of_run)
    else $error("end of file token not marked last");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the C-like source tokenizer with random stalls.
`timescale 1ns / 1ps

module testbench;

  typedef enum int {
    S_IDLE, S_PUNCT, S_SLASH, S_LCOM, S_BCOM, S_BSTAR, S_WORD, S_INT,
    S_FRAC, S_STR, S_QUOTE, S_QCHAR
  } scan_st_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cts_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cts_pkg::out_t out_data;

  c_like_source_tokenizer uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scanner state of the predictor.
  scan_st_t st;
  logic [7:0] held;
  cts_pkg::line_t cur_line;
  cts_pkg::offset_t pos;
  cts_pkg::offset_t tok_beg;
  logic [7:0] word_buf [cts_pkg::KEYWORD_MAX_LEN];
  logic word_long;

  cts_pkg::in_t pending_requests[$];
  cts_pkg::out_t token_queue[$];
  cts_pkg::out_t step_tokens[$];
  int errors = 0;
  longint cycle = 0;
  bit drain_wait = 1'b0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  function automatic cts_pkg::offset_t inc_off(cts_pkg::offset_t x);
    return (x == cts_pkg::OFS_SAT) ? cts_pkg::OFS_SAT : x + cts_pkg::offset_t'(1);
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit pair_lead(logic [7:0] c);
    return c == "<" || c == ">" || c == "*" || c == "+" || c == "-" || c == "!" ||
           c == "=" || c == "&" || c == "|" || c == "^";
  endfunction

  function automatic cts_pkg::kind_t one_kind(logic [7:0] c);
    case (c)
      "{": return 7'd0; "}": return 7'd1; "[": return 7'd2; "]": return 7'd3;
      "(": return 7'd4; ")": return 7'd5; "<": return 7'd8; ">": return 7'd11;
      ".": return 7'd12; ",": return 7'd13; ";": return 7'd14; ":": return 7'd15;
      "*": return 7'd17; "+": return 7'd20; "-": return 7'd24;
      "/": return cts_pkg::K_SLASH;
      "%": return 7'd27; "!": return 7'd29; "=": return 7'd31; "&": return 7'd34;
      "|": return 7'd37; "^": return 7'd39; "~": return 7'd40;
      default: return cts_pkg::K_NONE;
    endcase
  endfunction

  function automatic cts_pkg::kind_t two_kind(logic [7:0] a, logic [7:0] b);
    case (a)
      "<": return b == "=" ? 7'd6 : b == "<" ? 7'd7 : cts_pkg::K_NONE;
      ">": return b == "=" ? 7'd9 : b == ">" ? 7'd10 : cts_pkg::K_NONE;
      "*": return b == "=" ? 7'd16 : cts_pkg::K_NONE;
      "+": return b == "+" ? 7'd18 : b == "=" ? 7'd19 : cts_pkg::K_NONE;
      "-": return b == "-" ? 7'd21 : b == "=" ? 7'd22 : b == ">" ? 7'd23 :
                  cts_pkg::K_NONE;
      "!": return b == "=" ? 7'd28 : cts_pkg::K_NONE;
      "=": return b == "=" ? 7'd30 : cts_pkg::K_NONE;
      "&": return b == "=" ? 7'd32 : b == "&" ? 7'd33 : cts_pkg::K_NONE;
      "|": return b == "=" ? 7'd35 : b == "|" ? 7'd36 : cts_pkg::K_NONE;
      "^": return b == "=" ? 7'd38 : cts_pkg::K_NONE;
      default: return cts_pkg::K_NONE;
    endcase
  endfunction

  function automatic cts_pkg::kind_t word_kind(int n);
    string kw [18] = '{"using", "namespace", "class", "if", "else", "int", "float",
                       "double", "char", "string", "bool", "void", "while", "for",
                       "true", "false", "null", "return"};
    bit same;
    for (int i = 0; i < 18; i++) begin
      if (kw[i].len() == n) begin
        same = 1'b1;
        for (int j = 0; j < n; j++) if (word_buf[j] != kw[i][j]) same = 1'b0;
        if (same) return cts_pkg::K_KEY0 + cts_pkg::kind_t'(i);
      end
    end
    return cts_pkg::K_IDENT;
  endfunction

  task automatic add_token(cts_pkg::kind_t k, cts_pkg::offset_t s, cts_pkg::offset_t e,
                           cts_pkg::err_t er);
    cts_pkg::out_t t;
    t.token_kind = k;
    t.line_number = cur_line;
    t.start_offset = s;
    t.lexeme_length = (e >= s) ? e - s : '0;
    t.error_code = er;
    t.last_of_run = 1'b0;
    if (step_tokens.size() < 4) step_tokens = {step_tokens, t};
  endtask

  task automatic bump_line();
    if (cur_line != cts_pkg::LINE_SAT) cur_line++;
  endtask

  task automatic store_letter(logic [7:0] c, cts_pkg::offset_t off);
    cts_pkg::offset_t i;
    i = off - tok_beg;
    if (off == cts_pkg::OFS_SAT || i >= cts_pkg::KEYWORD_MAX_LEN) word_long = 1'b1;
    else word_buf[int'(i)] = c;
  endtask

  task automatic close_word(cts_pkg::offset_t e);
    int n;
    cts_pkg::kind_t k;
    n = int'(e - tok_beg);
    k = cts_pkg::K_IDENT;
    if (!word_long && n <= cts_pkg::KEYWORD_MAX_LEN) k = word_kind(n);
    add_token(k, tok_beg, e, cts_pkg::E_NONE);
    st = S_IDLE;
  endtask

  task automatic begin_token(logic [7:0] c, cts_pkg::offset_t off);
    cts_pkg::kind_t k;
    tok_beg = off;
    st = S_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0D) return;
    if (c == 8'h0A) begin
      bump_line();
      return;
    end
    if (c == "/") begin
      st = S_SLASH;
      return;
    end
    if (pair_lead(c)) begin
      held = c;
      st = S_PUNCT;
      return;
    end
    k = one_kind(c);
    if (k != cts_pkg::K_NONE) add_token(k, off, inc_off(off), cts_pkg::E_NONE);
    else if (c == 8'h22) st = S_STR;
    else if (c == 8'h27) st = S_QUOTE;
    else if (letter(c)) begin
      word_long = 1'b0;
      store_letter(c, off);
      st = S_WORD;
    end else if (digit(c)) st = S_INT;
    else add_token(cts_pkg::K_ERROR, off, inc_off(off), cts_pkg::E_CHAR);
  endtask

  task automatic scan_byte(logic [7:0] c, cts_pkg::offset_t off);
    bit again;
    cts_pkg::kind_t k;
    cts_pkg::offset_t q;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (st)
        S_PUNCT: begin
          k = two_kind(held, c);
          st = S_IDLE;
          if (k != cts_pkg::K_NONE) add_token(k, tok_beg, inc_off(off), cts_pkg::E_NONE);
          else begin
            add_token(one_kind(held), tok_beg, off, cts_pkg::E_NONE);
            again = 1'b1;
          end
        end
        S_SLASH: begin
          if (c == "/") st = S_LCOM;
          else if (c == "*") st = S_BCOM;
          else if (c == "=") begin
            add_token(cts_pkg::K_SLASH_EQ, tok_beg, inc_off(off), cts_pkg::E_NONE);
            st = S_IDLE;
          end else begin
            add_token(cts_pkg::K_SLASH, tok_beg, off, cts_pkg::E_NONE);
            st = S_IDLE;
            again = 1'b1;
          end
        end
        S_LCOM: begin
          if (c == 8'h0A) begin
            st = S_IDLE;
            again = 1'b1;
          end
        end
        S_BCOM, S_BSTAR: begin
          if (c == 8'h0A) bump_line();
          if (st == S_BSTAR && c == "/") st = S_IDLE;
          else st = (c == "*") ? S_BSTAR : S_BCOM;
        end
        S_WORD: begin
          if (letter(c) || digit(c)) store_letter(c, off);
          else begin
            close_word(off);
            again = 1'b1;
          end
        end
        S_INT, S_FRAC: begin
          if (digit(c)) begin
          end else if (c == "." && st == S_INT) st = S_FRAC;
          else begin
            if (c == "f" || c == "F")
              add_token(cts_pkg::K_FLOAT, tok_beg, inc_off(off), cts_pkg::E_NONE);
            else begin
              add_token(st == S_INT ? cts_pkg::K_INT : cts_pkg::K_DOUBLE, tok_beg, off,
                        cts_pkg::E_NONE);
              again = 1'b1;
            end
            st = S_IDLE;
          end
        end
        S_STR: begin
          if (c == 8'h22) begin
            add_token(cts_pkg::K_STRING, inc_off(tok_beg), off, cts_pkg::E_NONE);
            st = S_IDLE;
          end else if (c == 8'h0A) bump_line();
        end
        S_QUOTE: begin
          held = c;
          st = S_QCHAR;
        end
        S_QCHAR: begin
          if (c == 8'h27) begin
            if (held == 8'h0A) bump_line();
            add_token(cts_pkg::K_CHAR, inc_off(tok_beg), off, cts_pkg::E_NONE);
            st = S_IDLE;
          end else begin
            q = inc_off(tok_beg);
            add_token(cts_pkg::K_ERROR, q, q, cts_pkg::E_QUOTE);
            begin_token(held, q);
            again = 1'b1;
          end
        end
        default: begin_token(c, off);
      endcase
    end
  endtask

  task automatic restart_scanner();
    st = S_IDLE;
    held = '0;
    cur_line = cts_pkg::line_t'(1);
    pos = '0;
    tok_beg = '0;
    word_long = 1'b0;
  endtask

  task automatic predict_tokens(cts_pkg::in_t it);
    cts_pkg::offset_t off, q;
    step_tokens.delete();
    off = pos;
    if (it.end_of_input) begin
      if (st == S_QCHAR) begin
        q = inc_off(tok_beg);
        add_token(cts_pkg::K_ERROR, q, q, cts_pkg::E_QUOTE);
        begin_token(held, q);
      end
      q = inc_off(tok_beg);
      case (st)
        S_PUNCT: add_token(one_kind(held), tok_beg, off, cts_pkg::E_NONE);
        S_SLASH: add_token(cts_pkg::K_SLASH, tok_beg, off, cts_pkg::E_NONE);
        S_WORD: close_word(off);
        S_INT: add_token(cts_pkg::K_INT, tok_beg, off, cts_pkg::E_NONE);
        S_FRAC: add_token(cts_pkg::K_DOUBLE, tok_beg, off, cts_pkg::E_NONE);
        S_STR: add_token(cts_pkg::K_ERROR, q, off, cts_pkg::E_STRING);
        S_QUOTE: add_token(cts_pkg::K_ERROR, q, q, cts_pkg::E_QUOTE);
        default: ;
      endcase
      st = S_IDLE;
      add_token(cts_pkg::K_EOF, off, off, cts_pkg::E_NONE);
      restart_scanner();
    end else begin
      pos = inc_off(pos);
      scan_byte(it.byte_value, off);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) token_queue = {token_queue, step_tokens[i]};
  endtask

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycle, what);
    errors++;
  endtask

  task automatic push_text(string s);
    cts_pkg::in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.byte_value = s[i];
      it.end_of_input = 1'b0;
      pending_requests = {pending_requests, it};
    end
  endtask

  task automatic push_end();
    cts_pkg::in_t it;
    it.byte_value = 8'($urandom);
    it.end_of_input = 1'b1;
    pending_requests = {pending_requests, it};
  endtask

  function automatic string random_lexeme();
    string frags [26] = '{"using ", "namespace", "class ", "if(", "else{", "int ", "float",
      "double ", "char ", "string", "bool ", "void", "while", "for ", "true", "false ",
      "null;", "return ", "x_9 ", "12.5f ", "3.25 ", "0 ", "\"ab\nc\" ", "'q' ",
      "/* a*\n*/", "// c\n"};
    string ops [12] = '{"<=", "<<", ">=", ">>", "*=", "++", "+=", "--", "-=", "->", "/=",
                        "!=="};
    string marks;
    string s;
    marks = "&&||^=~%,.:[]{}";
    case ($urandom_range(0, 5))
      0, 1, 2: s = frags[$urandom_range(0, 25)];
      3: s = ops[$urandom_range(0, 11)];
      4: begin
        s = " ";
        s[0] = 8'($urandom);
      end
      default: s = marks.substr($urandom_range(0, 13), $urandom_range(0, 13));
    endcase
    return s;
  endfunction

  // Driver.
  int in_gap = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_tokens(in_data);
        void'(pending_requests.pop_front());
        in_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (drain_wait && token_queue.size() == 0 && !(in_valid && in_ready)) drain_wait = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 && !drain_wait) begin
          in_valid <= 1'b1;
          in_data <= pending_requests[0];
          if (pending_requests[0].byte_value == 8'h40 && !pending_requests[0].end_of_input)
            drain_wait = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (!stall_done && cycle >= 300) begin
      stall_left <= 60;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor.
  int out_gap = 0;
  always @(posedge clk) begin
    cts_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) report("token with no request to cause it");
        else begin
          want = token_queue.pop_front();
          if (out_data.token_kind != want.token_kind)
            report($sformatf("kind %0d, want %0d", out_data.token_kind, want.token_kind));
          if (out_data.line_number != want.line_number)
            report($sformatf("line %0d, want %0d", out_data.line_number, want.line_number));
          if (out_data.start_offset != want.start_offset)
            report($sformatf("start %0d, want %0d", out_data.start_offset, want.start_offset));
          if (out_data.lexeme_length != want.lexeme_length)
            report($sformatf("length %0d, want %0d", out_data.lexeme_length,
                             want.lexeme_length));
          if (out_data.error_code != want.error_code)
            report($sformatf("error %0d, want %0d", out_data.error_code, want.error_code));
          if (out_data.last_of_run != want.last_of_run)
            report($sformatf("last %0d, want %0d", out_data.last_of_run, want.last_of_run));
        end
        out_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cts_pkg::in_t it;
    restart_scanner();
    push_text("{}[]()<=<<<>=>>>.,;:*=*++++=+---=->-/=/%!=!===&=&&&|=|||^=^~ ");
    push_text("using namespace x; 12 3.5 7f 2.f \"s\" 'a' '' 'ab $\n");
    push_end();
    push_text("\"open");
    push_end();
    push_text("'x");
    push_end();
    push_text("/* never closed");
    push_end();
    push_text("abc");
    push_end();
    push_end();
    it.end_of_input = 1'b0;
    for (int b = 0; b < 256; b += 17) begin
      it.byte_value = 8'(b);
      pending_requests = {pending_requests, it};
    end
    it.byte_value = 8'hFF;
    pending_requests = {pending_requests, it};
    push_end();
    for (int n = 0; n < 15; n++) begin
      push_text(random_lexeme());
      if ($urandom_range(0, 25) == 0) push_end();
      if (n == 5) push_text("@");
      if (n == 11) push_text("@");
    end
    push_end();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (cycle > 200000) begin
      $display("simulation failed");
      $finish;
    end else if (rst_n && pending_requests.size() == 0 && !in_valid &&
                 token_queue.size() == 0) begin
      repeat (20) @(posedge clk);
      if (token_queue.size() == 0 && errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
    end
  end

endmodule

FILE: files.f
design/cts_pkg.sv
design/cts_front.sv
design/cts_back.sv
design/c_like_source_tokenizer.sv
tb/testbench.sv
